>>> design/cll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cll_pkg;

  localparam int IDX_W = 6;
  localparam int VAL_W = 17;
  localparam int SUM_W = 56;
  localparam int CNT_W = 32;

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] REG_LATTICE_SIZE = 2'd0;
  localparam logic [1:0] REG_COUPLING     = 2'd1;
  localparam logic [1:0] REG_WARMUP       = 2'd2;
  localparam logic [1:0] REG_TARGET       = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] node;
    logic [VAL_W-1:0] load_value;
    logic [IDX_W-1:0] link_a;
    logic [IDX_W-1:0] link_b;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic [SUM_W-1:0] error_sum;
    logic [CNT_W-1:0] sweeps_done;
    logic             sweep_end;
  } out_rsp_t;

  // classified request passed from front to back
  typedef struct packed {
    logic             op;
    logic             last;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] link_a;
    logic [IDX_W-1:0] link_b;
    logic [VAL_W-1:0] load_value;
  } work_t;

  typedef struct packed {
    logic [VAL_W-1:0] coupling;
    logic [15:0]      warmup;
    logic [VAL_W-1:0] target;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD0,
    ST_RD1,
    ST_MUL0,
    ST_MUL1,
    ST_MIX,
    ST_SQ,
    ST_ACC
  } back_st_t;

  function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage
`default_nettype wire

>>> design/cll_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cll_queue import cll_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire work_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output work_t      pop_data
);

  work_t         q_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (QW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> design/cll_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cll_front import cll_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire in_req_t                          in_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]   act_size,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output work_t                                 push_data
);

  localparam int SW = $clog2(MAX_NODES+1);
  localparam int LW = (SW > IDX_W) ? SW : IDX_W;
  localparam int TAB_N = 2**IDX_W;

  // index wrap modulo MAX_NODES as a constant table
  logic [IDX_W-1:0] wrap_tab [TAB_N];
  logic [IDX_W-1:0] node_w;

  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_wrap
    assign wrap_tab[gi] = IDX_W'(gi % MAX_NODES);
  end

  assign node_w     = wrap_tab[in_data.node];
  assign in_stall   = !push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data            = '0;
    push_data.op         = in_data.operation;
    push_data.node       = node_w;
    push_data.link_a     = wrap_tab[in_data.link_a];
    push_data.link_b     = wrap_tab[in_data.link_b];
    push_data.load_value = sat_one(in_data.load_value);
    push_data.last       = (in_data.operation == OP_UPDATE) &&
                           (LW'(node_w) == (LW'(act_size) - LW'(1)));
  end

endmodule
`default_nettype wire

>>> design/cll_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cll_back import cll_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cfg_t                           cfg,
  input  wire logic [$clog2(MAX_NODES+1)-1:0] act_size,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire work_t                          pop_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output out_rsp_t                            out_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // two physical banks; per node, cur_ptr picks the bank with the committed
  // value and nxt_ptr the bank with the next-sweep value (equal when aliased)
  logic [VAL_W-1:0] mem0_r [MAX_NODES];
  logic [VAL_W-1:0] mem1_r [MAX_NODES];
  logic [VAL_W-1:0] b0_q0_r, b0_q1_r, b1_q0_r, b1_q1_r;
  logic [MAX_NODES-1:0] cur_ptr_r, cur_ptr_nxt;
  logic [MAX_NODES-1:0] nxt_ptr_r, nxt_ptr_nxt;

  back_st_t         state_r, state_nxt;
  work_t            work_r;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] sweeps_r, sweeps_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, rsp_nxt;
  logic             out_load;

  logic [NW-1:0]    na, aa, ba, ra0, ra1;
  logic             sel_x_r, sel_a_r, sel_b_r;
  logic [VAL_W-1:0] x_r, xa_r, xb;
  logic [VAL_W-1:0] omx, ome, f_val;
  logic [33:0]      mul_x;
  logic [30:0]      prod_r;
  logic [17:0]      sum_ab_r;
  logic [33:0]      term1_r;
  logic [34:0]      term2_r;
  logic [35:0]      num;
  logic [18:0]      shr;
  logic [VAL_W-1:0] nv_mix, nv_r;
  logic [VAL_W-1:0] dev;
  logic [33:0]      sq_r;
  logic [SUM_W:0]   sum_ext;

  logic             we, wbank;
  logic [VAL_W-1:0] wd;
  logic             can_emit;

  assign na = NW'(work_r.node);
  assign aa = NW'(work_r.link_a);
  assign ba = NW'(work_r.link_b);
  assign ra0 = (state_r == ST_RD1) ? ba : na;
  assign ra1 = aa;

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // datapath
  assign xb     = sel_b_r ? b1_q0_r : b0_q0_r;
  assign omx    = ONE_Q16 - x_r;
  assign mul_x  = 34'(x_r) * 34'(omx);
  assign f_val  = prod_r[30:14];          // (4*x*(1-x)) >> 16
  assign ome    = ONE_Q16 - cfg.coupling;
  assign num    = {1'b0, term1_r, 1'b0} + 36'(term2_r);
  assign shr    = num[35:17];
  assign nv_mix = (shr > 19'(ONE_Q16)) ? ONE_Q16 : shr[VAL_W-1:0];
  assign dev    = (nv_r >= cfg.target) ? nv_r - cfg.target : cfg.target - nv_r;
  assign sum_ext = {1'b0, acc_r} + (SUM_W+1)'(sq_r);

  always_ff @(posedge clk) begin
    b0_q0_r <= mem0_r[ra0];
    b0_q1_r <= mem0_r[ra1];
    b1_q0_r <= mem1_r[ra0];
    b1_q1_r <= mem1_r[ra1];
    if (we && !wbank) begin
      mem0_r[na] <= wd;
    end
    if (we && wbank) begin
      mem1_r[na] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      work_r <= pop_data;
    end
    if (out_load) begin
      out_data_r <= rsp_nxt;
    end
    case (state_r)
      ST_RD0: begin
        sel_x_r <= cur_ptr_r[na];
        sel_a_r <= cur_ptr_r[aa];
      end
      ST_RD1: begin
        x_r     <= sel_x_r ? b1_q0_r : b0_q0_r;
        xa_r    <= sel_a_r ? b1_q1_r : b0_q1_r;
        sel_b_r <= cur_ptr_r[ba];
      end
      ST_MUL0: begin
        prod_r   <= mul_x[30:0];
        sum_ab_r <= 18'(xa_r) + 18'(xb);
      end
      ST_MUL1: begin
        term1_r <= 34'(ome) * 34'(f_val);
        term2_r <= 35'(cfg.coupling) * 35'(sum_ab_r);
      end
      ST_MIX: nv_r <= nv_mix;
      ST_SQ:  sq_r <= 34'(dev) * 34'(dev);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sweeps_nxt    = sweeps_r;
    cur_ptr_nxt   = cur_ptr_r;
    nxt_ptr_nxt   = nxt_ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    rsp_nxt       = out_data_r;
    pop_ready     = 1'b0;
    we            = 1'b0;
    wbank         = 1'b0;
    wd            = nv_r;
    case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = (pop_data.op == OP_UPDATE) ? ST_RD0 : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (can_emit) begin
          // write the committed copy in the bank not holding the next value
          we              = 1'b1;
          wbank           = !nxt_ptr_r[na];
          wd              = work_r.load_value;
          cur_ptr_nxt[na] = wbank;
          acc_nxt         = '0;
          sweeps_nxt      = '0;
          out_valid_nxt   = 1'b1;
          out_load        = 1'b1;
          rsp_nxt         = '{new_value: work_r.load_value, error_sum: '0,
                              sweeps_done: '0, sweep_end: 1'b0};
          state_nxt       = ST_IDLE;
        end
      end
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_MUL0;
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (can_emit) begin
          we              = 1'b1;
          wbank           = !sel_x_r;
          nxt_ptr_nxt[na] = wbank;
          if (sweeps_r >= CNT_W'(cfg.warmup)) begin
            acc_nxt = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
          end
          if (work_r.last) begin
            if (sweeps_r != CNT_MAX) begin
              sweeps_nxt = sweeps_r + 1'b1;
            end
            // commit: current follows next for every node in use
            for (int i = 0; i < MAX_NODES; i++) begin
              if (i < int'(act_size)) begin
                cur_ptr_nxt[i] = nxt_ptr_nxt[i];
              end
            end
          end
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          rsp_nxt       = '{new_value: nv_r, error_sum: acc_nxt,
                            sweeps_done: sweeps_nxt, sweep_end: work_r.last};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      sweeps_r    <= '0;
      cur_ptr_r   <= '0;
      nxt_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      sweeps_r    <= sweeps_nxt;
      cur_ptr_r   <= cur_ptr_nxt;
      nxt_ptr_r   <= nxt_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/coupled_logistic_lattice_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The back-end sequencer takes a new request only once the last one is done: a load
// passes through ST_LOAD, an update through ST_RD0 to ST_ACC (three lattice reads over
// the ST_RD0 and ST_RD1 states, then a multiply chain); the output waits on out_stall.
// A 2-entry request queue lets the input side run ahead of the back end.
// Reset (rst_n low, synchronous) clears the queue, sweep count, error sum and output
// valid, and loads the registers with their defaults; node values read as unset.
module coupled_logistic_lattice_update_unit import cll_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_req_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_rsp_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_NODES+1);
  localparam int CW = (SW > 7) ? SW : 7;

  logic [6:0]       size_r;
  logic [VAL_W-1:0] coupling_r;
  logic [15:0]      warmup_r;
  logic [VAL_W-1:0] target_r;
  logic [CW-1:0]    size_ext;
  logic [SW-1:0]    act_size;
  cfg_t             cfg;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  work_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= 7'd50;
      coupling_r <= 17'd39322;
      warmup_r   <= 16'd100;
      target_r   <= 17'd49152;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LATTICE_SIZE: size_r     <= cfg_data[6:0];
        REG_COUPLING:     coupling_r <= cfg_data;
        REG_WARMUP:       warmup_r   <= cfg_data[15:0];
        REG_TARGET:       target_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp lattice size into 2..MAX_NODES
  assign size_ext = CW'(size_r);
  always_comb begin
    if (size_ext < CW'(2)) begin
      act_size = SW'(2);
    end else if (size_ext > CW'(MAX_NODES)) begin
      act_size = SW'(MAX_NODES);
    end else begin
      act_size = SW'(size_ext);
    end
  end

  assign cfg = '{coupling: sat_one(coupling_r), warmup: warmup_r,
                 target: sat_one(target_r)};

  cll_front #(.MAX_NODES(MAX_NODES)) u_front (
    .in_data    (in_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .act_size   (act_size),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cll_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cll_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .act_size  (act_size),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
